// File: sv/bdre_pkg.sv
package bdre_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_CAP = 8'd0,
    REG_HEAP_CAP = 8'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEAP   = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUT_HEAP = 2'd1,
    ST_OUT_DIFF = 2'd2
  } status_e;

  localparam logic [31:0] DIFF_CAP_RST = 32'd256;
  localparam logic [31:0] HEAP_CAP_RST = 32'd4096;

  typedef struct packed {
    logic [7:0] old_byte;
    logic [7:0] new_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  heap_byte;
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic [1:0]  status;
    logic        final_res;
  } out_t;

endpackage

// File: sv/binary_diff_run_encoder.sv
// binary diff run encoder
// input channel: one old/new byte pair per transaction (in_valid_i, in_stall_o,
//   in_data_i), last flags the final pair of an image
// output channel: result transactions (out_valid_o, out_stall_i, out_data_o):
//   heap bytes, run records and one final status per image, final_res marks
//   the last result caused by one input pair
// config channel: cfg_valid_i/cfg_ready_o with register index and data,
//   index 0 diff capacity, index 1 heap capacity; always ready
// results of a pair are written into the result queue and presented from its head
// throughput: one pair per cycle while each pair gives at most one result and
//   the output is not stalled; a pair with more results holds later pairs back,
//   set by the four-entry result queue and the one-result-per-cycle output port
// a pair is taken while at most one result is still queued, so in_stall_o
//   comes straight from the queue count
// stall on the output holds the head result and fills the queue, which then
//   raises in_stall_o; nothing is dropped
// reset empties the queue, clears position, run, counters and error, and
//   loads the capacities with 256 records and 4096 heap bytes; the last pair
//   of an image clears the same state again but keeps the capacities
module binary_diff_run_encoder #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bdre_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bdre_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdre_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bdre_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bdre_pkg::*;

  localparam int unsigned QDEPTH = 4;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   in_run_q, in_run_d;
  logic [31:0]            len_q, len_d;
  logic [31:0]            rec_q, rec_d;
  logic [31:0]            heap_q, heap_d;
  logic [1:0]             err_q, err_d;
  logic [31:0]            diff_cap_q, heap_cap_q;

  out_t                   slot_q [QDEPTH];
  out_t                   slot_d [QDEPTH];
  logic [2:0]             cnt_q, cnt_d;

  out_t                   res [3];
  logic [1:0]             n_new;
  logic [63:0]            start_ext;
  logic                   in_acc, out_pop;
  logic [2:0]             base;
  logic [2:0]             wr_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q > 3'd1);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = slot_q[0];
  assign out_pop     = out_valid_o && !out_stall_i;

  // per pair update and result build
  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    in_run_d = in_run_q;
    len_d    = len_q;
    rec_d    = rec_q;
    heap_d   = heap_q;
    err_d    = err_q;
    n_new    = 2'd0;
    start_ext = '0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (err_d == ST_OK && rec_d >= diff_cap_q) begin
      err_d = ST_OUT_DIFF;
    end

    if (err_d == ST_OK) begin
      if (in_data_i.old_byte != in_data_i.new_byte) begin
        if (heap_d >= heap_cap_q) begin
          err_d = ST_OUT_HEAP;
        end else begin
          if (!in_run_d) begin
            in_run_d = 1'b1;
            start_d  = pos_q;
            len_d    = '0;
          end
          len_d  = len_d + 32'd1;
          heap_d = heap_d + 32'd1;
          res[n_new].kind      = KIND_HEAP;
          res[n_new].heap_byte = in_data_i.new_byte;
          n_new = n_new + 2'd1;
        end
      end
      // close an open run on an equal byte or at the end of the image
      if (err_d != ST_OUT_HEAP && in_run_d &&
          (in_data_i.old_byte == in_data_i.new_byte || in_data_i.last)) begin
        start_ext = 64'(start_d);
        res[n_new].kind       = KIND_RUN;
        res[n_new].run_start  = start_ext[31:0];
        res[n_new].run_length = len_d;
        n_new    = n_new + 2'd1;
        in_run_d = 1'b0;
        len_d    = '0;
        rec_d    = rec_d + 32'd1;
        if (rec_d >= diff_cap_q) begin
          err_d = ST_OUT_DIFF;
        end
      end
    end

    pos_d = pos_q + OFFSET_BITS'(1);

    if (in_data_i.last) begin
      res[n_new].kind   = KIND_STATUS;
      res[n_new].status = err_d;
      n_new    = n_new + 2'd1;
      pos_d    = '0;
      start_d  = '0;
      in_run_d = 1'b0;
      len_d    = '0;
      rec_d    = '0;
      heap_d   = '0;
      err_d    = ST_OK;
    end

    if (n_new != 2'd0) begin
      res[n_new - 2'd1].final_res = 1'b1;
    end
  end

  // result queue: pop at the head, append behind what stays
  always_comb begin
    base   = cnt_q - {2'b00, out_pop};
    wr_idx = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (out_pop && i < QDEPTH - 1) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
    end
    cnt_d = base;
    if (in_acc) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(j) < n_new) begin
          wr_idx = base + 3'(j);
          slot_d[wr_idx[1:0]] = res[j];
        end
      end
      cnt_d = base + {1'b0, n_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      start_q    <= '0;
      in_run_q   <= 1'b0;
      len_q      <= '0;
      rec_q      <= '0;
      heap_q     <= '0;
      err_q      <= ST_OK;
      diff_cap_q <= DIFF_CAP_RST;
      heap_cap_q <= HEAP_CAP_RST;
      cnt_q      <= '0;
    end else begin
      if (in_acc) begin
        pos_q    <= pos_d;
        start_q  <= start_d;
        in_run_q <= in_run_d;
        len_q    <= len_d;
        rec_q    <= rec_d;
        heap_q   <= heap_d;
        err_q    <= err_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_DIFF_CAP) begin
          diff_cap_q <= cfg_data_i;
        end else if (cfg_index_i == REG_HEAP_CAP) begin
          heap_cap_q <= cfg_data_i;
        end
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last |=> pos_q == '0 && !in_run_q && err_q == ST_OK)
    else $error("state not cleared after last pair");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !in_acc |=> $stable(err_q))
    else $error("error code changed without a pair");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_RUN |-> out_data_o.run_length != 32'd0)
    else $error("empty run record");

  a_run_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_run_q |-> len_q == 32'd0)
    else $error("run length kept without an open run");

endmodule

// File: tb/diff_run_checker.sv
`timescale 1ns / 100ps

module diff_run_checker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  bdre_pkg::in_t                     in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  bdre_pkg::out_t                    out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [bdre_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bdre_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import bdre_pkg::*;

  logic [31:0]            max_records;
  logic [31:0]            max_heap;
  logic [OFFSET_BITS-1:0] offset;
  logic                   run_open;
  logic [OFFSET_BITS-1:0] run_start;
  logic [31:0]            run_len;
  logic [31:0]            records;
  logic [31:0]            heap_fill;
  status_e                error_st;
  out_t                   expected_q[$];
  out_t                   item_res[$];
  int                     errors = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic out_t make_result(input kind_e k, input logic [7:0] hb,
                                       input logic [31:0] rs, input logic [31:0] rl,
                                       input status_e st);
    out_t r;
    r.kind       = k;
    r.heap_byte  = hb;
    r.run_start  = rs;
    r.run_length = rl;
    r.status     = st;
    r.final_res  = 1'b0;
    return r;
  endfunction

  task automatic clear_state();
    offset    = '0;
    run_open  = 1'b0;
    run_start = '0;
    run_len   = '0;
    records   = '0;
    heap_fill = '0;
    error_st  = ST_OK;
  endtask

  task automatic close_run();
    if (run_open) begin
      item_res.push_back(make_result(KIND_RUN, '0, 32'(run_start), run_len, ST_OK));
      run_open = 1'b0;
      run_len  = '0;
      records++;
      if (records >= max_records) begin
        error_st = ST_OUT_DIFF;
      end
    end
  endtask

  // results of one byte pair, in the order heap byte, record, status
  task automatic encode_pair(input in_t p);
    out_t tail;
    item_res.delete();
    if (error_st == ST_OK && records >= max_records) begin
      error_st = ST_OUT_DIFF;
    end
    if (error_st == ST_OK) begin
      if (p.old_byte != p.new_byte) begin
        if (heap_fill >= max_heap) begin
          error_st = ST_OUT_HEAP;
        end else begin
          if (!run_open) begin
            run_open  = 1'b1;
            run_start = offset;
            run_len   = '0;
          end
          run_len++;
          heap_fill++;
          item_res.push_back(make_result(KIND_HEAP, p.new_byte, '0, '0, ST_OK));
          if (p.last) begin
            close_run();
          end
        end
      end else begin
        close_run();
      end
    end
    offset++;
    if (p.last) begin
      item_res.push_back(make_result(KIND_STATUS, '0, '0, '0, error_st));
      clear_state();
    end
    if (item_res.size() > 0) begin
      tail = item_res.pop_back();
      tail.final_res = 1'b1;
      item_res.push_back(tail);
    end
    foreach (item_res[i]) begin
      expected_q.push_back(item_res[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      max_records = DIFF_CAP_RST;
      max_heap    = HEAP_CAP_RST;
      clear_state();
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result transaction with nothing expected, kind %0d",
                           out_data_i.kind));
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", out_data_i.kind, want.kind));
          if (out_data_i.heap_byte !== want.heap_byte)
            report($sformatf("heap_byte %0h, expected %0h",
                             out_data_i.heap_byte, want.heap_byte));
          if (out_data_i.run_start !== want.run_start)
            report($sformatf("run_start %0d, expected %0d",
                             out_data_i.run_start, want.run_start));
          if (out_data_i.run_length !== want.run_length)
            report($sformatf("run_length %0d, expected %0d",
                             out_data_i.run_length, want.run_length));
          if (out_data_i.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_data_i.status, want.status));
          if (out_data_i.final_res !== want.final_res)
            report($sformatf("final_res %0b, expected %0b",
                             out_data_i.final_res, want.final_res));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_pair(in_data_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DIFF_CAP: max_records = cfg_data_i;
          REG_HEAP_CAP: max_heap = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bdre_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int          RANDOM_ITEMS = 230;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          gap_pct = 0;
  int          items_sent = 0;
  int unsigned cycles = 0;

  binary_diff_run_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  diff_run_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req && !calm) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_pair(input logic [7:0] old_b, input logic [7:0] new_b,
                           input logic last_b);
    in_t p;
    p.old_byte = old_b;
    p.new_byte = new_b;
    p.last     = last_b;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_image(input int len, input int diff_pct);
    logic [7:0] o;
    for (int i = 0; i < len; i++) begin
      o = 8'($urandom);
      send_pair(o, ($urandom_range(0, 99) < diff_pct) ? o ^ 8'($urandom_range(1, 255)) : o,
                i == len - 1);
    end
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_caps(input logic [31:0] diff_cap, input logic [31:0] heap_cap);
    write_reg(REG_DIFF_CAP, diff_cap);
    write_reg(REG_HEAP_CAP, heap_cap);
  endtask

  function automatic logic [31:0] pick_cap(input int small_max);
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'($urandom_range(1, small_max));
      2: return 32'hffff_ffff;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 20;
      2: return 60;
      default: return 100;
    endcase
  endfunction

  initial begin
    int base;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacities
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'hff, 8'h00, 1'b1);
    send_pair(8'h00, 8'hff, 1'b0);
    send_pair(8'h55, 8'haa, 1'b0);
    send_pair(8'h12, 8'h12, 1'b0);
    send_pair(8'haa, 8'h55, 1'b0);
    send_pair(8'h80, 8'h7f, 1'b1);
    drain();

    // zero diff capacity on identical images
    set_caps(32'd0, 32'hffff_ffff);
    send_pair(8'h3c, 8'h3c, 1'b0);
    send_pair(8'hc3, 8'hc3, 1'b1);
    drain();

    // records used up, identical tail
    set_caps(32'd1, 32'd2);
    send_pair(8'h01, 8'h02, 1'b0);
    send_pair(8'h10, 8'h10, 1'b0);
    send_pair(8'h20, 8'h20, 1'b1);
    drain();

    // heap overflow inside a run, then error pending
    set_caps(32'd4, 32'd2);
    send_pair(8'h00, 8'h01, 1'b0);
    send_pair(8'h00, 8'h02, 1'b0);
    send_pair(8'h00, 8'h03, 1'b0);
    send_pair(8'h00, 8'h04, 1'b1);
    drain();

    // zero heap capacity
    set_caps(32'd4, 32'd0);
    send_pair(8'hf0, 8'h0f, 1'b1);
    drain();

    // diff capacity lowered below the record count mid image
    set_caps(32'd8, 32'd8);
    send_pair(8'h01, 8'h02, 1'b0);
    send_pair(8'h03, 8'h03, 1'b0);
    send_pair(8'h04, 8'h05, 1'b0);
    send_pair(8'h06, 8'h06, 1'b0);
    drain();
    write_reg(REG_DIFF_CAP, 32'd1);
    send_pair(8'h07, 8'h07, 1'b1);
    drain();

    base = items_sent;
    for (int phase = 0; items_sent - base < RANDOM_ITEMS; phase++) begin
      drain();
      case (phase)
        0: set_caps(32'hffff_ffff, 32'hffff_ffff);
        1: set_caps(DIFF_CAP_RST, HEAP_CAP_RST);
        2: set_caps(32'hffff_ffff, 32'hffff_ffff);
        default: set_caps(pick_cap(6), pick_cap(24));
      endcase
      gap_pct = (phase % 3 == 2) ? 0 : 25;
      calm = (RANDOM_ITEMS - (items_sent - base)) < 40;
      if (phase == 2) begin
        // receiver holds off while a long differing image keeps coming
        hold_req = 1'b1;
        send_image(40, 100);
      end
      repeat ($urandom_range(2, 5)) begin
        send_image(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12), pick_pct());
      end
    end

    calm = 1'b1;
    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
